/* rtl/tbrl_pkg.sv */
// package with constants and types for the token bucket rate limiter
package tbrl_pkg;

  localparam int TOKEN_BITS = 16;
  localparam int NOW_BITS   = 48;
  localparam int TIME_BITS  = 48;
  localparam int PROD_BITS  = TIME_BITS + TOKEN_BITS;
  localparam int CNT_BITS   = $clog2(PROD_BITS);
  localparam int CFG_BITS   = 2;

  localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(TOKEN_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(PROD_BITS - 1);

  localparam logic [TOKEN_BITS-1:0] CAPACITY_RESET = TOKEN_BITS'(10);
  localparam logic [TOKEN_BITS-1:0] REFILL_RESET   = TOKEN_BITS'(1);
  localparam logic [TOKEN_BITS-1:0] INTERVAL_RESET = TOKEN_BITS'(1000);

  typedef enum logic [CFG_BITS-1:0] {
    CFG_CAPACITY      = 2'd0,
    CFG_REFILL_TOKENS = 2'd1,
    CFG_INTERVAL_MS   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_t;

endpackage

/* rtl/token_bucket_rate_limiter.sv */
// token bucket rate limiter top level with shift-add multiply and restoring divide
// A request goes from the check straight to the finish when the bucket already holds the
// tokens asked for; else a refill is worked out first (elapsed time times refill_tokens by
// shift-add, then a one-bit-per-cycle restoring divide by interval_ms), and in both cases the
// result may wait in the output register. in_stall is high while a request is in work.
// Configuration writes are always taken and must be done while idle.
module token_bucket_rate_limiter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tbrl_pkg::TOKEN_BITS-1:0]  request_tokens,
  input  logic [tbrl_pkg::NOW_BITS-1:0]    now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             granted,
  output logic [tbrl_pkg::TOKEN_BITS-1:0]  tokens_left,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbrl_pkg::CFG_BITS-1:0]    cfg_index,
  input  logic [tbrl_pkg::TOKEN_BITS-1:0]  cfg_data
);
  import tbrl_pkg::*;

  state_t state, state_next;

  logic [TOKEN_BITS-1:0] capacity;
  logic [TOKEN_BITS-1:0] refill_tokens;
  logic [TOKEN_BITS-1:0] interval_ms;
  logic [TOKEN_BITS-1:0] available_tokens;
  logic [TIME_BITS-1:0]  last_refill_time;

  logic [TOKEN_BITS-1:0] req;
  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  elapsed;
  logic [TOKEN_BITS-1:0] rate_sh;
  logic [TOKEN_BITS-1:0] divisor;
  logic [PROD_BITS-1:0]  prod;
  logic [TOKEN_BITS-1:0] rem;
  logic [TOKEN_BITS-1:0] quot;
  logic                  sat;
  logic [CNT_BITS-1:0]   cnt;
  logic                  res_granted;
  logic [TOKEN_BITS-1:0] res_left;

  logic                  accept;
  logic                  load_out;
  logic                  out_free;

  logic                  first_ok;
  logic [TOKEN_BITS:0]   rsh;
  logic                  ge;
  logic                  fill_nz;
  logic [TOKEN_BITS-1:0] fill;
  logic [TOKEN_BITS:0]   sum_raw;
  logic [TOKEN_BITS-1:0] sum;
  logic                  second_ok;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = first_ok ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    cfg_ready = 1'b1;
    out_free  = !out_valid || !out_stall;
    accept    = in_valid && (state == ST_IDLE);
    load_out  = (state == ST_FINISH) && out_free;
  end

  // datapath helpers
  always_comb begin
    first_ok  = (req <= available_tokens);
    rsh       = {rem, prod[PROD_BITS-1]};
    ge        = (rsh >= {1'b0, divisor});
    fill_nz   = sat || (quot != '0);
    fill      = (sat || (quot > capacity)) ? capacity : quot;
    sum_raw   = {1'b0, available_tokens} + {1'b0, fill};
    sum       = (sum_raw > {1'b0, capacity}) ? capacity : sum_raw[TOKEN_BITS-1:0];
    second_ok = (req <= sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration and bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= CAPACITY_RESET;
      refill_tokens    <= REFILL_RESET;
      interval_ms      <= INTERVAL_RESET;
      available_tokens <= '0;
      last_refill_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY:      capacity      <= cfg_data;
          CFG_REFILL_TOKENS: refill_tokens <= cfg_data;
          CFG_INTERVAL_MS:   interval_ms   <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CHECK && first_ok) begin
        available_tokens <= available_tokens - req;
      end
      if (state == ST_APPLY) begin
        available_tokens <= second_ok ? sum - req : sum;
        if (fill_nz) last_refill_time <= now;
      end
    end
  end

  // shared shift-add and restoring divide sequence
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req <= request_tokens;
          now <= now_ms[TIME_BITS-1:0];
        end
      end
      ST_CHECK: begin
        elapsed     <= (now >= last_refill_time) ? now - last_refill_time : '0;
        rate_sh     <= refill_tokens;
        divisor     <= (interval_ms == '0) ? TOKEN_BITS'(1) : interval_ms;
        prod        <= '0;
        cnt         <= '0;
        res_granted <= 1'b1;
        res_left    <= available_tokens - req;
      end
      ST_MUL: begin
        prod    <= {prod[PROD_BITS-2:0], 1'b0}
                   + (rate_sh[TOKEN_BITS-1] ? {{TOKEN_BITS{1'b0}}, elapsed} : '0);
        rate_sh <= {rate_sh[TOKEN_BITS-2:0], 1'b0};
        cnt     <= (cnt == MUL_LAST) ? '0 : cnt + 1'b1;
        rem     <= '0;
        quot    <= '0;
        sat     <= 1'b0;
      end
      ST_DIV: begin
        rem  <= ge ? rsh[TOKEN_BITS-1:0] - divisor : rsh[TOKEN_BITS-1:0];
        quot <= {quot[TOKEN_BITS-2:0], ge};
        sat  <= sat | quot[TOKEN_BITS-1];
        prod <= {prod[PROD_BITS-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      ST_APPLY: begin
        res_granted <= second_ok;
        res_left    <= second_ok ? sum - req : sum;
      end
      ST_FINISH: begin
        if (load_out) begin
          granted     <= res_granted;
          tokens_left <= res_left;
        end
      end
      default: ;
    endcase
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_CHECK)
    else $error("accepted request did not start the check");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result shown without finishing a request");

  a_div_follows_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && cnt == MUL_LAST) |=> (state == ST_DIV && cnt == '0))
    else $error("divide did not start after multiply");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_DIV) |-> in_stall)
    else $error("input open while a request is in work");

endmodule
